### design/lcg_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the line color gradient pipeline.
package lcg_pkg;

  localparam int COORD_BITS = 16;
  localparam int COLOR_W    = 24;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = COLOR_W / CHAN_W;

  // Stage 0: operand select, stages 1..12: blend and divide, stage 13: output.
  localparam int NSTAGE = 14;

  // Per-item flags that ride along the channel pipeline.
  typedef struct packed {
    logic              zero;  // segment has zero length
    logic              neg;   // numerator and segment length differ in sign
    logic              sat;   // quotient is 256 or more
    logic [CHAN_W-1:0] tgt;   // end color channel
  } lcg_ctl_t;

endpackage

### design/lcg_channel.sv
`timescale 1ns / 1ps
// One 8-bit color channel: blend numerator, sign fold and pipelined divide.
module lcg_channel #(
  parameter int CoordBits = lcg_pkg::COORD_BITS
) (
  input  logic                                clk_i,
  input  logic [lcg_pkg::NSTAGE-1:1]          en_i,
  input  logic signed [CoordBits:0]           place_i,
  input  logic signed [CoordBits:0]           dist_i,
  input  logic [lcg_pkg::CHAN_W-1:0]          from_i,
  input  logic [lcg_pkg::CHAN_W-1:0]          to_i,
  output logic [lcg_pkg::CHAN_W-1:0]          chan_o
);
  import lcg_pkg::*;

  localparam int CW = CoordBits + 1;   // coordinate difference
  localparam int PW = CW + CHAN_W + 1; // one product
  localparam int NW = PW + 1;          // product sum

  logic signed [CHAN_W:0] diff;
  lcg_ctl_t               ctl1_d;
  lcg_ctl_t               ctl3_d;
  lcg_ctl_t               ctl4_d;

  logic signed [PW-1:0]   pa_q, pd_q;
  logic signed [CW-1:0]   dist1_q, dist2_q;
  logic signed [NW-1:0]   num_q;
  logic [NW-1:0]          mag_q;
  logic [CW-1:0]          dmag_q [3:11];
  logic [NW-1:0]          rem_q  [4:11];
  logic [CHAN_W-1:0]      quo_q  [4:12];
  lcg_ctl_t               ctl_q  [1:12];
  logic [CHAN_W-1:0]      chan_q;

  assign diff = $signed({1'b0, to_i}) - $signed({1'b0, from_i});

  always_comb begin
    ctl1_d      = '0;
    ctl1_d.zero = (dist_i == '0);
    ctl1_d.tgt  = to_i;
    ctl3_d      = ctl_q[2];
    ctl3_d.neg  = num_q[NW-1] ^ dist2_q[CW-1];
    ctl4_d      = ctl_q[3];
    ctl4_d.sat  = (mag_q >= (NW'(dmag_q[3]) << CHAN_W));
  end

  // Stage 1: num = a*dist + (b-a)*place, products first.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      pa_q     <= $signed({1'b0, from_i}) * dist_i;
      pd_q     <= diff * place_i;
      dist1_q  <= dist_i;
      ctl_q[1] <= ctl1_d;
    end
  end

  // Stage 2: sum.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      num_q    <= NW'(pa_q) + NW'(pd_q);
      dist2_q  <= dist1_q;
      ctl_q[2] <= ctl_q[1];
    end
  end

  // Stage 3: fold signs into magnitudes.
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      mag_q     <= num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
      dmag_q[3] <= dist2_q[CW-1] ? CW'(-dist2_q) : CW'(dist2_q);
      ctl_q[3]  <= ctl3_d;
    end
  end

  // Stage 4: saturation check, seed the divider.
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      rem_q[4]  <= mag_q;
      quo_q[4]  <= '0;
      dmag_q[4] <= dmag_q[3];
      ctl_q[4]  <= ctl4_d;
    end
  end

  // Stages 5..12: one restoring quotient bit each, MSB first.
  for (genvar i = 0; i < CHAN_W; i++) begin : g_step
    logic [NW-1:0] shd;
    logic          ge;

    assign shd = NW'(dmag_q[4+i]) << (CHAN_W - 1 - i);
    assign ge  = (rem_q[4+i] >= shd);

    always_ff @(posedge clk_i) begin
      if (en_i[5+i]) begin
        quo_q[5+i] <= {quo_q[4+i][CHAN_W-2:0], ge};
        ctl_q[5+i] <= ctl_q[4+i];
      end
    end

    // Advance the divisor and partial remainder to the next step.
    if (i < CHAN_W - 1) begin : g_dmag
      always_ff @(posedge clk_i) begin
        if (en_i[5+i]) begin
          dmag_q[5+i] <= dmag_q[4+i];
          rem_q[5+i]  <= ge ? (rem_q[4+i] - shd) : rem_q[4+i];
        end
      end
    end
  end

  // Stage 13: pick the final channel value.
  always_ff @(posedge clk_i) begin
    if (en_i[13]) begin
      if (ctl_q[12].zero) begin
        chan_q <= ctl_q[12].tgt;
      end else if (ctl_q[12].neg) begin
        chan_q <= '0;
      end else if (ctl_q[12].sat) begin
        chan_q <= '1;
      end else begin
        chan_q <= quo_q[12];
      end
    end
  end

  assign chan_o = chan_q;

endmodule

### design/line_color_gradient.sv
`timescale 1ns / 1ps
// Top level of the line color gradient: per-pixel linear RGB blend pipeline.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one pixel of a line: the
//   segment start and end on the major axis, the pixel x and y, the line
//   extents in x and y, and the two 0xRRGGBB endpoint colors. A beat is taken
//   at a rising edge with in_valid_i high and in_stall_o low.
//   Output channel (out_valid_o / out_stall_i) returns pixel_color_o, one beat
//   per input beat, in order.
//   Throughput: one beat per cycle while out_stall_i is low. A taken beat
//   reaches out_valid_o through the 14 register stages (operand select,
//   two multiply/sum stages, sign fold, saturation check, eight one-bit
//   divide steps, output register).
//   Reset clears every stage valid bit; the block is empty and ready after it.
//   When the receiver stalls, the output beat holds and items behind it close
//   up into empty stages; in_stall_o rises only once every stage is full.
module line_color_gradient #(
  parameter int CoordBits = lcg_pkg::COORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [CoordBits-1:0]       seg_start_i,
  input  logic signed [CoordBits-1:0]       seg_end_i,
  input  logic signed [CoordBits-1:0]       pos_x_i,
  input  logic signed [CoordBits-1:0]       pos_y_i,
  input  logic [CoordBits-1:0]              delta_x_i,
  input  logic [CoordBits-1:0]              delta_y_i,
  input  logic [lcg_pkg::COLOR_W-1:0]       color_from_i,
  input  logic [lcg_pkg::COLOR_W-1:0]       color_to_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lcg_pkg::COLOR_W-1:0]       pixel_color_o
);
  import lcg_pkg::*;

  localparam int CW = CoordBits + 1;

  logic [NSTAGE-1:0]       v_q, v_d;
  logic [NSTAGE-1:0]       en;
  logic signed [CoordBits-1:0] pos;
  logic signed [CW-1:0]    place_q, dist_q;
  logic [COLOR_W-1:0]      from_q, to_q;

  // A stage may load when it is empty or when some stage after it is empty
  // or the output is drained; this closes bubbles without a ripple chain.
  for (genvar k = 0; k < NSTAGE; k++) begin : g_en
    assign en[k] = ~out_stall_i | ~(&v_q[NSTAGE-1:k]);
  end

  always_comb begin
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NSTAGE; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Stage 0: major axis select (x wins a tie), place and length.
  assign pos = (delta_x_i >= delta_y_i) ? pos_x_i : pos_y_i;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      place_q <= CW'(pos) - CW'(seg_start_i);
      dist_q  <= CW'(seg_end_i) - CW'(seg_start_i);
      from_q  <= color_from_i;
      to_q    <= color_to_i;
    end
  end

  // One blend/divide lane per color channel; all lanes share the valid bits.
  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    lcg_channel #(
      .CoordBits(CoordBits)
    ) u_chan (
      .clk_i  (clk_i),
      .en_i   (en[NSTAGE-1:1]),
      .place_i(place_q),
      .dist_i (dist_q),
      .from_i (from_q[c*CHAN_W +: CHAN_W]),
      .to_i   (to_q[c*CHAN_W +: CHAN_W]),
      .chan_o (pixel_color_o[c*CHAN_W +: CHAN_W])
    );
  end

  assign in_stall_o  = ~en[0];
  assign out_valid_o = v_q[NSTAGE-1];

  // Input backpressure only when every stage holds an item and output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&v_q) && out_stall_i))
    else $error("input stalled while the pipeline has a free stage");

  // No beat in and none out: the number of items in flight is unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(in_valid_i && !in_stall_o) && !(out_valid_o && !out_stall_i))
    |=> ($countones(v_q) == $past($countones(v_q))))
    else $error("item lost or duplicated inside the pipeline");

  // A blocked first stage keeps its operands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && !en[0]) |=> (v_q[0] && $stable(place_q) && $stable(dist_q)))
    else $error("stage 0 operands changed while held");

endmodule

### sim/lcg_checker.sv
`timescale 1ns / 1ps
// Checker for line_color_gradient: watches both channels and compares each output beat.
module lcg_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic signed [lcg_pkg::COORD_BITS-1:0] seg_start_i,
  input  logic signed [lcg_pkg::COORD_BITS-1:0] seg_end_i,
  input  logic signed [lcg_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic signed [lcg_pkg::COORD_BITS-1:0] pos_y_i,
  input  logic [lcg_pkg::COORD_BITS-1:0]        delta_x_i,
  input  logic [lcg_pkg::COORD_BITS-1:0]        delta_y_i,
  input  logic [lcg_pkg::COLOR_W-1:0]           color_from_i,
  input  logic [lcg_pkg::COLOR_W-1:0]           color_to_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic [lcg_pkg::COLOR_W-1:0]           pixel_color_i,
  output int                                    fail_count_o,
  output int                                    pending_o,
  output int                                    checked_o
);
  import lcg_pkg::*;

  logic [COLOR_W-1:0] color_fifo[$];
  logic [COLOR_W-1:0] want;
  int                 fails;
  int                 checked;

  // Blend one pixel: pick the major-axis coordinate, then mix each channel
  // with exact integer math, truncate toward zero and clamp to 0..255.
  function automatic logic [COLOR_W-1:0] blend_pixel(
    input logic signed [COORD_BITS-1:0] s,
    input logic signed [COORD_BITS-1:0] e,
    input logic signed [COORD_BITS-1:0] px,
    input logic signed [COORD_BITS-1:0] py,
    input logic [COORD_BITS-1:0]        dx,
    input logic [COORD_BITS-1:0]        dy,
    input logic [COLOR_W-1:0]           cf,
    input logic [COLOR_W-1:0]           ct
  );
    longint             pos;
    longint             place;
    longint             span;
    longint             num;
    longint             q;
    logic [COLOR_W-1:0] mix;
    pos   = (dx >= dy) ? longint'(px) : longint'(py);
    place = pos - longint'(s);
    span  = longint'(e) - longint'(s);
    mix   = '0;
    if (span == 0) begin
      return ct;
    end
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      num = longint'(cf[ch*CHAN_W +: CHAN_W]) * (span - place)
          + longint'(ct[ch*CHAN_W +: CHAN_W]) * place;
      q = num / span;
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      mix[ch*CHAN_W +: CHAN_W] = q[CHAN_W-1:0];
    end
    return mix;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_fifo.delete();
      fails        = 0;
      checked      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // Queue the expected color of every accepted input beat.
      if (in_valid_i && !in_stall_i) begin
        color_fifo.push_back(blend_pixel(seg_start_i, seg_end_i, pos_x_i, pos_y_i,
                                         delta_x_i, delta_y_i, color_from_i, color_to_i));
      end
      // Compare every accepted output beat with the oldest expectation.
      if (out_valid_i && !out_stall_i) begin
        if (color_fifo.size() == 0) begin
          $error("pixel_color beat with no expectation: actual %06h", pixel_color_i);
          fails++;
        end else begin
          want = color_fifo.pop_front();
          checked++;
          if (pixel_color_i !== want) begin
            $error("pixel_color mismatch: expected %06h, actual %06h", want, pixel_color_i);
            fails++;
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= color_fifo.size();
      checked_o    <= checked;
    end
  end

endmodule

### sim/line_color_gradient_tb.sv
`timescale 1ns / 1ps
// Testbench top for line_color_gradient: drives pixels, stalls the output, reports the verdict.
module line_color_gradient_tb;
  import lcg_pkg::*;

  // Far above the worst-case run with both sides idling.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 500;
  localparam int COORD_MAX = 2 ** (COORD_BITS - 1) - 1;
  localparam int COORD_MIN = -(2 ** (COORD_BITS - 1));

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [COORD_BITS-1:0] seg_start = '0;
  logic signed [COORD_BITS-1:0] seg_end = '0;
  logic signed [COORD_BITS-1:0] pos_x = '0;
  logic signed [COORD_BITS-1:0] pos_y = '0;
  logic [COORD_BITS-1:0]        delta_x = '0;
  logic [COORD_BITS-1:0]        delta_y = '0;
  logic [COLOR_W-1:0]           color_from = '0;
  logic [COLOR_W-1:0]           color_to = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [COLOR_W-1:0]           pixel_color;

  int fail_count;
  int pending;
  int checked;
  int cycles = 0;
  int pixels_sent = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  line_color_gradient DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .seg_start_i   (seg_start),
    .seg_end_i     (seg_end),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .delta_x_i     (delta_x),
    .delta_y_i     (delta_y),
    .color_from_i  (color_from),
    .color_to_i    (color_to),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .pixel_color_o (pixel_color)
  );

  lcg_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .seg_start_i   (seg_start),
    .seg_end_i     (seg_end),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .delta_x_i     (delta_x),
    .delta_y_i     (delta_y),
    .color_from_i  (color_from),
    .color_to_i    (color_to),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .pixel_color_i (pixel_color),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // Receiver side: stall at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("line_color_gradient test failed");
      $finish;
    end
  end

  // Drive one pixel beat, idling first at the sender's rate, and hold it
  // until the block takes it. Entered and left right after a rising edge.
  task automatic drive_pixel(
    input logic signed [COORD_BITS-1:0] s,
    input logic signed [COORD_BITS-1:0] e,
    input logic signed [COORD_BITS-1:0] px,
    input logic signed [COORD_BITS-1:0] py,
    input logic [COORD_BITS-1:0]        dx,
    input logic [COORD_BITS-1:0]        dy,
    input logic [COLOR_W-1:0]           cf,
    input logic [COLOR_W-1:0]           ct
  );
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    seg_start  <= s;
    seg_end    <= e;
    pos_x      <= px;
    pos_y      <= py;
    delta_x    <= dx;
    delta_y    <= dy;
    color_from <= cf;
    color_to   <= ct;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  function automatic int clamp_coord(input int v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // One random pixel. Most land inside their segment, as a rasterizer sends
  // them; the rest fall outside, sit on zero-length segments, or are noise.
  task automatic random_pixel();
    int                    kind;
    int                    s;
    int                    e;
    int                    lo;
    int                    hi;
    int                    pos;
    int                    other;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    kind = $urandom_range(99);
    s = int'($urandom_range(65535)) - 32768;
    if ($urandom_range(1) == 1) begin
      e = clamp_coord(s + int'($urandom_range(600)) - 300);
    end else begin
      e = int'($urandom_range(65535)) - 32768;
    end
    lo = (s < e) ? s : e;
    hi = (s < e) ? e : s;
    other = int'($urandom_range(65535)) - 32768;
    if (kind < 70) begin
      pos = lo + int'($urandom_range(hi - lo));
    end else if (kind < 82) begin
      if ($urandom_range(1) == 1) pos = clamp_coord(hi + 1 + int'($urandom_range(2000)));
      else pos = clamp_coord(lo - 1 - int'($urandom_range(2000)));
    end else if (kind < 88) begin
      e = s;
      pos = int'($urandom_range(65535)) - 32768;
    end else begin
      pos = int'($urandom_range(65535)) - 32768;
    end
    dx = COORD_BITS'($urandom);
    dy = COORD_BITS'($urandom);
    if ($urandom_range(7) == 0) dy = dx;
    // Put the chosen coordinate on the axis the deltas make major.
    if (dx >= dy) begin
      drive_pixel(COORD_BITS'(s), COORD_BITS'(e), COORD_BITS'(pos), COORD_BITS'(other),
                  dx, dy, COLOR_W'($urandom), COLOR_W'($urandom));
    end else begin
      drive_pixel(COORD_BITS'(s), COORD_BITS'(e), COORD_BITS'(other), COORD_BITS'(pos),
                  dx, dy, COLOR_W'($urandom), COLOR_W'($urandom));
    end
  endtask

  initial begin
    int directed;
    // Hold reset, then release it once.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct    <= 31;
    receiver_stall_pct <= 60;

    // Endpoints of a plain segment: start color, end color, midpoint.
    drive_pixel(0, 100, 0, 9, 10, 5, 24'hFF0000, 24'h0000FF);
    drive_pixel(0, 100, 100, 9, 10, 5, 24'hFF0000, 24'h0000FF);
    drive_pixel(0, 100, 50, 9, 10, 5, 24'h000000, 24'hFFFFFF);
    // Zero-length segment returns the end color.
    drive_pixel(7, 7, 3, -3, 4, 2, 24'hABCDEF, 24'h123456);
    drive_pixel(-32768, -32768, 32767, -32768, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'h000000);
    // Full coordinate span in both directions.
    drive_pixel(-32768, 32767, 32767, 0, 16'hFFFF, 0, 24'h000000, 24'hFFFFFF);
    drive_pixel(-32768, 32767, -32768, 0, 16'hFFFF, 0, 24'h000000, 24'hFFFFFF);
    drive_pixel(32767, -32768, 0, 0, 16'hFFFF, 0, 24'hFF00FF, 24'h00FF00);
    drive_pixel(32767, -32768, -32768, 0, 16'hFFFF, 0, 24'h12AB34, 24'hF0067E);
    // Pixel outside the segment: clamp high and low.
    drive_pixel(0, 10, 32767, 0, 20, 1, 24'h000000, 24'hFFFFFF);
    drive_pixel(0, 10, -32768, 0, 20, 1, 24'h000000, 24'hFFFFFF);
    drive_pixel(0, 10, 11, 0, 20, 1, 24'hFFFFFF, 24'h000000);
    // Small negative blends: truncation toward zero, then clamp at zero.
    drive_pixel(0, 3, -1, 0, 5, 5, 24'h000000, 24'h010101);
    drive_pixel(0, 3, -4, 0, 5, 5, 24'h000000, 24'h010101);
    // Equal deltas pick x; smaller x delta picks y.
    drive_pixel(0, 8, 2, 6, 500, 500, 24'h000000, 24'h808080);
    drive_pixel(0, 8, 2, 6, 0, 0, 24'h000000, 24'h808080);
    drive_pixel(0, 8, 2, 6, 3, 9, 24'h000000, 24'h808080);
    drive_pixel(0, 8, 2, 6, 0, 16'hFFFF, 24'h000000, 24'h808080);
    // Same color at both ends, and mixed channels on a long segment.
    drive_pixel(-1000, 1000, 17, 0, 9, 9, 24'hFFFFFF, 24'hFFFFFF);
    drive_pixel(-1000, 1000, 17, 0, 9, 9, 24'h000000, 24'h000000);
    drive_pixel(-30000, 30001, 12345, -5, 16'h8000, 16'h7FFF, 24'h12AB34, 24'hF0067E);
    drive_pixel(5, -5, 0, 0, 16'h7FFF, 16'h8000, 24'h00FF80, 24'hFF0080);
    directed = pixels_sent;

    repeat (RANDOM_PER_PHASE) random_pixel();

    // Swap the idle rates of the two sides.
    sender_idle_pct    <= 60;
    receiver_stall_pct <= 31;
    repeat (RANDOM_PER_PHASE) random_pixel();

    // Back to back, no idling on either side.
    sender_idle_pct    <= 0;
    receiver_stall_pct <= 0;
    repeat (RANDOM_PER_PHASE) random_pixel();
    in_valid <= 1'b0;

    // Drain the pipeline, then idle for longer than its depth.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (NSTAGE + 4) @(posedge clk);

    $display("Sent %0d pixels (%0d directed, rest random over three idle phases);",
             pixels_sent, directed);
    $display("checked %0d colors in %0d cycles, %0d failures.", checked, cycles, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("line_color_gradient test passed");
    end else begin
      $display("line_color_gradient test failed");
    end
    $finish;
  end

endmodule
